[sv/rigid_vertex_skinning_unit_defines.svh]
`ifndef RIGID_VERTEX_SKINNING_UNIT_DEFINES_SVH
`define RIGID_VERTEX_SKINNING_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RVS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RVS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rvs_pkg.sv]
package rvs_pkg;

	localparam int MAX_BONES_DEF  = 128;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int WORDS_PER_BONE = 12;
	localparam int ROOT_BITS      = 32;

	localparam logic CMD_SKIN = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [7:0] ACT_BONES_RST = 8'd1;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] nrm;
		logic             last;
		logic             big;
	} vtx_side_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[sv/rvs_palette.sv]
module rvs_palette #(
	parameter int MAX_BONES = rvs_pkg::MAX_BONES_DEF,
	parameter int BW        = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [3:0]           wsel,
	input  logic [BW-1:0]        waddr,
	input  logic [31:0]          wdata,
	input  logic                 re,
	input  logic [BW-1:0]        raddr,
	output logic [rvs_pkg::WORDS_PER_BONE-1:0][31:0] rdata
);

	for (genvar b = 0; b < rvs_pkg::WORDS_PER_BONE; b++) begin : g_bank
		logic [31:0] mem [0:MAX_BONES-1];

		always_ff @(posedge clk) begin
			if (we && (wsel == 4'(b))) begin
				mem[waddr] <= wdata;
			end
			if (re) begin
				rdata[b] <= mem[raddr];
			end
		end
	end

endmodule

[sv/rvs_xform.sv]
module rvs_xform #(
	parameter int FRAC_BITS = rvs_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_s1,
	input  logic [rvs_pkg::WORDS_PER_BONE-1:0][31:0] mw_s1,
	input  logic [2:0][31:0] pos_s1,
	input  logic [2:0][31:0] nrm_s1,
	input  logic             last_s1,
	output logic             vld_s6,
	output logic [63:0]      ssq_s6,
	output rvs_pkg::vtx_side_t side_s6
);

	localparam logic [63:0] NORM_MIN_SQ =
		64'((64'd1 << (2 * FRAC_BITS)) / 64'd100000000000000);
	localparam logic signed [63:0] RND = 64'((64'd1 << FRAC_BITS) - 64'd1);

	logic signed [63:0] pp_s2 [0:2][0:2];
	logic signed [63:0] np_s2 [0:2][0:2];
	logic [2:0][31:0]   t_s2;
	logic               last_s2, vld_s2;

	logic signed [63:0] pp_s3 [0:2][0:2];
	logic signed [63:0] np_s3 [0:2][0:2];
	logic [2:0][31:0]   t_s3;
	logic               last_s3, vld_s3;

	logic [2:0][31:0]   pos_s4, nrm_s4;
	logic               last_s4, vld_s4;

	logic [63:0]        sq_s5 [0:2];
	logic [2:0][31:0]   pos_s5, nrm_s5;
	logic               last_s5, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pp_s2[r][c] <= $signed(mw_s1[c*3+r]) * $signed(pos_s1[c]);
					np_s2[r][c] <= $signed(mw_s1[c*3+r]) * $signed(nrm_s1[c]);
					pp_s3[r][c] <= (pp_s2[r][c] + (pp_s2[r][c][63] ? RND : 64'sd0))
						>>> FRAC_BITS;
					np_s3[r][c] <= (np_s2[r][c] + (np_s2[r][c][63] ? RND : 64'sd0))
						>>> FRAC_BITS;
				end
				t_s2[r] <= mw_s1[9+r];
				pos_s4[r] <= rvs_pkg::sat32(66'($signed(t_s3[r])) + 66'(pp_s3[r][0])
					+ 66'(pp_s3[r][1]) + 66'(pp_s3[r][2]));
				nrm_s4[r] <= rvs_pkg::sat32(66'(np_s3[r][0]) + 66'(np_s3[r][1])
					+ 66'(np_s3[r][2]));
				sq_s5[r] <= 64'($signed(nrm_s4[r]) * $signed(nrm_s4[r]));
			end
			t_s3    <= t_s2;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			pos_s5  <= pos_s4;
			nrm_s5  <= nrm_s4;
			last_s5 <= last_s4;
			ssq_s6  <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			side_s6.pos  <= pos_s5;
			side_s6.nrm  <= nrm_s5;
			side_s6.last <= last_s5;
			side_s6.big  <= (sq_s5[0] + sq_s5[1] + sq_s5[2]) > NORM_MIN_SQ;
		end
	end

endmodule

[sv/rvs_isqrt.sv]
module rvs_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [63:0]        in_s,
	input  rvs_pkg::vtx_side_t in_side,
	output logic               out_vld,
	output logic [31:0]        out_root,
	output rvs_pkg::vtx_side_t out_side
);

	localparam int NSTG = rvs_pkg::ROOT_BITS;

	logic               vld_s  [0:NSTG];
	logic [63:0]        rem_s  [0:NSTG];
	logic [31:0]        root_s [0:NSTG];
	rvs_pkg::vtx_side_t side_s [0:NSTG];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_s;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		localparam int BI = NSTG - 1 - k;
		logic [64:0] trial;

		assign trial = ({33'd0, root_s[k]} << (BI + 1)) | (65'd1 << (2 * BI));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_s[k]} >= trial) begin
					rem_s[k+1]  <= rem_s[k] - trial[63:0];
					root_s[k+1] <= root_s[k] | (32'd1 << BI);
				end else begin
					rem_s[k+1]  <= rem_s[k];
					root_s[k+1] <= root_s[k];
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[NSTG];
	assign out_root = root_s[NSTG];
	assign out_side = side_s[NSTG];

endmodule

[sv/rvs_ndiv.sv]
module rvs_ndiv #(
	parameter int FRAC_BITS = rvs_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [31:0]        in_len,
	input  rvs_pkg::vtx_side_t in_side,
	output logic               out_vld,
	output logic [5:0][31:0]   out_res,
	output logic               out_last
);

	localparam int NSTG = FRAC_BITS + 1;
	localparam int DW   = 33 + FRAC_BITS;

	logic               vld_s  [0:NSTG];
	logic [DW-1:0]      rem_s  [0:NSTG][0:2];
	logic [NSTG-1:0]    quo_s  [0:NSTG][0:2];
	logic [31:0]        len_s  [0:NSTG];
	rvs_pkg::vtx_side_t side_s [0:NSTG];

	for (genvar c = 0; c < 3; c++) begin : g_in
		logic [31:0] mag;
		assign mag = in_side.nrm[c][31] ? (32'd0 - in_side.nrm[c]) : in_side.nrm[c];
		assign rem_s[0][c] = DW'(mag) << FRAC_BITS;
		assign quo_s[0][c] = '0;
	end
	assign vld_s[0]  = in_vld;
	assign len_s[0]  = in_len;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		localparam int BI = NSTG - 1 - k;
		logic [DW-1:0] dvs;

		assign dvs = DW'(len_s[k]) << BI;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					if (rem_s[k][c] >= dvs) begin
						rem_s[k+1][c] <= rem_s[k][c] - dvs;
						quo_s[k+1][c] <= quo_s[k][c] | (NSTG'(1) << BI);
					end else begin
						rem_s[k+1][c] <= rem_s[k][c];
						quo_s[k+1][c] <= quo_s[k][c];
					end
				end
				len_s[k+1]  <= len_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				out_res[c] <= side_s[NSTG].pos[c];
				if (side_s[NSTG].big) begin
					out_res[3+c] <= side_s[NSTG].nrm[c][31]
						? (32'd0 - 32'(quo_s[NSTG][c])) : 32'(quo_s[NSTG][c]);
				end else begin
					out_res[3+c] <= side_s[NSTG].nrm[c];
				end
			end
			out_last <= side_s[NSTG].last;
		end
	end

endmodule

[sv/rigid_vertex_skinning_unit.sv]
// channel   dir  handshake               payload
// s_axis    in   s_tvalid / s_tready     s_tdata, s_tuser = cmd, s_tlast = last_vertex
// m_axis    out  m_tvalid / m_tready     m_tdata, m_tlast = last
// cfg       in   cfg_valid / cfg_ready   cfg_data = active bone count
//
// One beat per clock in and out while the output is not stalled. Stages (Q16.16 data):
// palette read, 5 multiply/sum stages, 32 square-root stages, FRAC_BITS+1 divide
// stages, output register. Load beats write the palette and drop out as bubbles.
// Reset clears valid bits and sets the active bone count to 1; palette is not cleared.
// All stages share one enable: they hold while m_tvalid is high and m_tready low.
module rigid_vertex_skinning_unit #(
	parameter int MAX_BONES = rvs_pkg::MAX_BONES_DEF,
	parameter int FRAC_BITS = rvs_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// bone[7:0], word_sel[11:8], word_value[43:12], pos_x[75:44], pos_y[107:76],
	// pos_z[139:108], norm_x[171:140], norm_y[203:172], norm_z[235:204], zero pad
	input  logic [239:0] s_tdata,
	input  logic         s_tuser, // cmd
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], out_nx[127:96], out_ny[159:128],
	// out_nz[191:160]
	output logic [191:0] m_tdata,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);

	localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

	logic               en;
	logic [7:0]         act_bones_q;
	logic [7:0]         bone;
	logic [3:0]         wsel;
	logic [8:0]         limit;
	logic [BW-1:0]      rd_bone;
	logic               we;
	logic [rvs_pkg::WORDS_PER_BONE-1:0][31:0] mw_s1;
	logic [2:0][31:0]   pos_s1, nrm_s1;
	logic               last_s1, vld_s1;
	logic               vld_s6;
	logic [63:0]        ssq_s6;
	rvs_pkg::vtx_side_t side_s6, side_rt;
	logic               vld_rt;
	logic [31:0]        len_rt;
	logic [5:0][31:0]   res;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_bones_q <= rvs_pkg::ACT_BONES_RST;
		end else if (cfg_valid) begin
			act_bones_q <= cfg_data;
		end
	end

	assign bone  = s_tdata[7:0];
	assign wsel  = s_tdata[11:8];
	assign limit = ({1'b0, act_bones_q} < 9'(MAX_BONES)) ? {1'b0, act_bones_q}
		: 9'(MAX_BONES);
	assign rd_bone = ({1'b0, bone} >= limit) ? '0 : bone[BW-1:0];
	assign we = s_tvalid && en && (s_tuser == rvs_pkg::CMD_LOAD)
		&& ({1'b0, bone} < 9'(MAX_BONES))
		&& (wsel < 4'(rvs_pkg::WORDS_PER_BONE));

	rvs_palette #(.MAX_BONES(MAX_BONES), .BW(BW)) u_palette (
		.clk   (clk),
		.we    (we),
		.wsel  (wsel),
		.waddr (bone[BW-1:0]),
		.wdata (s_tdata[43:12]),
		.re    (en),
		.raddr (rd_bone),
		.rdata (mw_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid && (s_tuser == rvs_pkg::CMD_SKIN);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1  <= s_tdata[139:44];
			nrm_s1  <= s_tdata[235:140];
			last_s1 <= s_tlast;
		end
	end

	rvs_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_s1  (vld_s1),
		.mw_s1   (mw_s1),
		.pos_s1  (pos_s1),
		.nrm_s1  (nrm_s1),
		.last_s1 (last_s1),
		.vld_s6  (vld_s6),
		.ssq_s6  (ssq_s6),
		.side_s6 (side_s6)
	);

	rvs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.in_s     (ssq_s6),
		.in_side  (side_s6),
		.out_vld  (vld_rt),
		.out_root (len_rt),
		.out_side (side_rt)
	);

	rvs_ndiv #(.FRAC_BITS(FRAC_BITS)) u_ndiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_rt),
		.in_len   (len_rt),
		.in_side  (side_rt),
		.out_vld  (m_tvalid),
		.out_res  (res),
		.out_last (m_tlast)
	);

	assign m_tdata = res;

endmodule

[sv/rvs_checker.sv]
`include "rigid_vertex_skinning_unit_defines.svh"

module rvs_checker #(
	parameter int FRAC_BITS = rvs_pkg::FRAC_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [191:0] m_tdata,
	input logic         m_tlast,
	input logic         cfg_valid,
	input logic         cfg_ready
);

	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

	`RVS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")
	`RVS_ASSERT_NOW(a_in_ready, m_tready || !m_tvalid, s_tready, "input stalled while output free")
	`RVS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")
	`RVS_ASSERT_NOW(a_nx_unit, m_tvalid, ($signed(m_tdata[127:96]) <= ONE) && ($signed(m_tdata[127:96]) >= -ONE), "normal x beyond unit length")

endmodule

bind rigid_vertex_skinning_unit rvs_checker #(.FRAC_BITS(FRAC_BITS)) u_rvs_checker (.*);

[dv/rvs_skin_checker.sv]
module rvs_skin_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [239:0] s_tdata,
	input  logic         s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_data,
	output int           fails,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = rvs_pkg::FRAC_BITS_DEF;
	localparam int NBONES = rvs_pkg::MAX_BONES_DEF;
	localparam int WPB = rvs_pkg::WORDS_PER_BONE;

	typedef struct {
		logic [31:0] x, y, z, nx, ny, nz;
		logic        last;
	} skinned_vtx_t;

	logic [31:0]  palette [NBONES*WPB];
	logic [7:0]   act_bones;
	skinned_vtx_t skinned_q [$];

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b;
		if (p < 0)
			return -((-p) >> FRAC);
		return p >> FRAC;
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint mat(int base, int row, int col);
		return longint'($signed(palette[base + col*3 + row]));
	endfunction

	function automatic skinned_vtx_t skin(logic [239:0] d, logic lst);
		skinned_vtx_t     res;
		longint           p [3], n [3], r [3], o [3], acc, nacc, len;
		longint unsigned  sq;
		int               bone, lim, base;
		bone = d[7:0];
		lim  = (act_bones < NBONES) ? act_bones : NBONES;
		if (bone >= lim)
			bone = 0;
		base = bone * WPB;
		for (int k = 0; k < 3; k++) begin
			p[k] = longint'($signed(d[44 + 32*k +: 32]));
			n[k] = longint'($signed(d[140 + 32*k +: 32]));
		end
		sq = 0;
		for (int row = 0; row < 3; row++) begin
			acc  = mat(base, row, 3);
			nacc = 0;
			for (int col = 0; col < 3; col++) begin
				acc  += fx_mul(mat(base, row, col), p[col]);
				nacc += fx_mul(mat(base, row, col), n[col]);
			end
			o[row] = sat(acc);
			r[row] = sat(nacc);
			sq += longint'(r[row] * r[row]);
		end
		res.x = o[0][31:0];
		res.y = o[1][31:0];
		res.z = o[2][31:0];
		if (sq > 0) begin
			len = longint'(isqrt(sq));
			res.nx = 32'(sat((r[0] <<< FRAC) / len));
			res.ny = 32'(sat((r[1] <<< FRAC) / len));
			res.nz = 32'(sat((r[2] <<< FRAC) / len));
		end else begin
			res.nx = r[0][31:0];
			res.ny = r[1][31:0];
			res.nz = r[2][31:0];
		end
		res.last = lst;
		return res;
	endfunction

	task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		skinned_vtx_t e;
		if (!arst_n) begin
			act_bones = rvs_pkg::ACT_BONES_RST;
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				act_bones = cfg_data;
			if (s_tvalid && s_tready) begin
				if (s_tuser == rvs_pkg::CMD_LOAD) begin
					if (s_tdata[7:0] < NBONES && s_tdata[11:8] < WPB)
						palette[s_tdata[7:0]*WPB + s_tdata[11:8]] = s_tdata[43:12];
				end else begin
					skinned_q.push_back(skin(s_tdata, s_tlast));
				end
			end
			if (m_tvalid && m_tready) begin
				if (skinned_q.size() == 0) begin
					$error("output beat with no vertex outstanding");
					fails++;
				end else begin
					e = skinned_q.pop_front();
					cmp("out_x", e.x, m_tdata[31:0]);
					cmp("out_y", e.y, m_tdata[63:32]);
					cmp("out_z", e.z, m_tdata[95:64]);
					cmp("out_nx", e.nx, m_tdata[127:96]);
					cmp("out_ny", e.ny, m_tdata[159:128]);
					cmp("out_nz", e.nz, m_tdata[191:160]);
					cmp("last", 32'(e.last), 32'(m_tlast));
				end
			end
			pending = skinned_q.size();
		end
	end
endmodule

[dv/tb_rigid_vertex_skinning_unit.sv]
module tb_rigid_vertex_skinning_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN = 80;
	localparam int LOADED = 24;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [239:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_data = '0;
	int           fails, pending;
	int           cycles = 0;
	int           burst_left = 0;
	int           stall_mode = 0;
	logic [7:0]   cur_count = rvs_pkg::ACT_BONES_RST;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rigid_vertex_skinning_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	rvs_skin_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (cycles % 300 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 0);
			2: m_tready <= (cycles % 16) >= 12;
			default: m_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic beat(logic cmd, logic [7:0] bone, logic [3:0] wsel, logic [31:0] wval,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, logic lst);
		logic ok;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tlast  <= lst;
		s_tdata  <= {4'b0, nz, ny, nx, pz, py, px, wval, wsel, bone};
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic load_word(logic [7:0] bone, logic [3:0] wsel, logic [31:0] wval);
		beat(rvs_pkg::CMD_LOAD, bone, wsel, wval, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
	endtask

	task automatic vertex(logic [7:0] bone, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] nx, logic [31:0] ny, logic [31:0] nz, logic lst);
		beat(rvs_pkg::CMD_SKIN, bone, 4'($urandom), $urandom, px, py, pz, nx, ny, nz, lst);
	endtask

	task automatic set_bone_count(logic [7:0] v);
		logic ok;
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		repeat (64) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
		cur_count = v;
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
			2: case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0;
				default: return 32'hffff_ffff;
			endcase
			3: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
			default: return 32'($signed($urandom_range(0, 262144)) - 131072);
		endcase
	endfunction

	function automatic logic [31:0] rand_mword();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return 32'($signed($urandom_range(0, 262144)) - 131072);
	endfunction

	// only loaded bones are used in range; anything else falls back to bone 0
	function automatic logic [7:0] pick_bone();
		int lim, b;
		lim = (cur_count < rvs_pkg::MAX_BONES_DEF) ? int'(cur_count)
			: rvs_pkg::MAX_BONES_DEF;
		if ($urandom_range(0, 5) == 0 || lim == 0)
			b = $urandom_range(0, 255);
		else
			b = $urandom_range(0, lim - 1);
		if (b < lim && b >= LOADED && b != rvs_pkg::MAX_BONES_DEF - 1)
			b = $urandom_range(0, LOADED - 1);
		return 8'(b);
	endfunction

	task automatic rand_item();
		logic [7:0] b;
		if ($urandom_range(0, 9) < 7) begin
			b = pick_bone();
			if ($urandom_range(0, 19) == 0)
				vertex(b, rand_q(), rand_q(), rand_q(), 32'h0, 32'h0, 32'h0,
					1'($urandom_range(0, 1)));
			else
				vertex(b, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
					1'($urandom_range(0, 1)));
		end else if ($urandom_range(0, 9) == 0) begin
			load_word(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), $urandom);
		end else begin
			load_word(8'($urandom_range(0, rvs_pkg::MAX_BONES_DEF - 1)),
				4'($urandom_range(0, rvs_pkg::WORDS_PER_BONE - 1)), rand_mword());
		end
	endtask

	initial begin
		logic [7:0] counts [6];
		counts = '{8'd128, 8'd1, 8'd0, 8'd64, 8'd0, 8'd200};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// low bones and the top bone; bone 0 is identity plus offset, top bone is full-range
		for (int i = 0; i <= LOADED; i++) begin
			int b;
			b = (i == LOADED) ? rvs_pkg::MAX_BONES_DEF - 1 : i;
			for (int w = 0; w < rvs_pkg::WORDS_PER_BONE; w++) begin
				if (b == 0)
					load_word(8'd0, 4'(w), (w == 0 || w == 4 || w == 8) ? 32'h0001_0000
						: (w >= 9) ? 32'(w << 16) : 32'h0);
				else if (b == rvs_pkg::MAX_BONES_DEF - 1)
					load_word(8'(b), 4'(w), $urandom);
				else
					load_word(8'(b), 4'(w), (w >= 9) ? rand_q() : rand_mword());
			end
		end

		// one active bone: any other bone falls back to bone 0
		vertex(8'd5, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000,
			32'h0001_0000, 32'h0, 32'h0, 1'b0);
		vertex(8'd255, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		vertex(8'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		vertex(8'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
		vertex(8'd1, 32'hffff_ffff, 32'h1, 32'h0, 32'h1, 32'h0, 32'h0, 1'b0);
		load_word(8'd200, 4'd0, 32'hdead_beef);
		load_word(8'd1, 4'd12, 32'hdead_beef);
		load_word(8'd1, 4'd15, 32'hdead_beef);
		vertex(8'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0, 32'h0, 32'h0000_0001, 1'b0);

		set_bone_count(8'd128);
		vertex(8'd127, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b1);
		vertex(8'd127, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
		vertex(8'd128, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1);
		vertex(8'd20, 32'h1234_5678, 32'hedcb_a987, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b0);
		load_word(8'd127, 4'd11, 32'h7fff_ffff);
		load_word(8'd127, 4'd0, 32'h8000_0000);
		vertex(8'd127, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h1, 32'h1, 32'h1, 1'b1);

		foreach (counts[i]) begin
			set_bone_count(counts[i] != 0 ? counts[i] : 8'($urandom_range(1, 128)));
			repeat (175) rand_item();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[files.f]
+incdir+sv
sv/rvs_pkg.sv
sv/rvs_palette.sv
sv/rvs_xform.sv
sv/rvs_isqrt.sv
sv/rvs_ndiv.sv
sv/rigid_vertex_skinning_unit.sv
sv/rvs_checker.sv
dv/rvs_skin_checker.sv
dv/tb_rigid_vertex_skinning_unit.sv
